### rtl/cbfs_pkg.sv
// ----------------------------------------------------------------------------
// cbfs_pkg
// Shared constants and types of the compensated binomial field smoother.
// ----------------------------------------------------------------------------
package cbfs_pkg;

    // Four field lanes per grid cell: Pr, Pl, Sr, Sl
    localparam int NumFields   = 4;
    localparam int FieldPr     = 0;
    localparam int FieldPl     = 1;
    localparam int FieldSr     = 2;
    localparam int FieldSl     = 3;

    // Default value width, signed Q16.16
    localparam int ValueBitsDef = 32;

    // Result queue depth, at least six so that two cells in flight fit
    localparam int QueueDepth   = 8;

    // Results that one cell releases from the smoothing stage
    typedef struct packed {
        logic mid;   // compensated result of the cell two positions back
        logic last;  // final interior result, raised at row end
    } t_emit;

endpackage

### rtl/cbfs_ifs.sv
// ----------------------------------------------------------------------------
// cbfs_ifs
// Valid/ready channels of the smoother: cell input, result output and the
// edge mode write port.
// ----------------------------------------------------------------------------
interface cbfs_cell_if #(
    parameter int W = cbfs_pkg::ValueBitsDef
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pr_in;
    logic signed [W-1:0] pl_in;
    logic signed [W-1:0] sr_in;
    logic signed [W-1:0] sl_in;
    logic                row_end;

    modport source (output valid, pr_in, pl_in, sr_in, sl_in, row_end, input ready);
    modport sink   (input valid, pr_in, pl_in, sr_in, sl_in, row_end, output ready);
endinterface

interface cbfs_result_if #(
    parameter int W = cbfs_pkg::ValueBitsDef
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pr_out;
    logic signed [W-1:0] pl_out;
    logic signed [W-1:0] sr_out;
    logic signed [W-1:0] sl_out;
    logic                out_last;

    modport source (output valid, pr_out, pl_out, sr_out, sl_out, out_last, input ready);
    modport sink   (input valid, pr_out, pl_out, sr_out, sl_out, out_last, output ready);
endinterface

interface cbfs_cfg_if;
    logic valid;
    logic ready;
    logic edge_mode;

    modport source (output valid, edge_mode, input ready);
    modport sink   (input valid, edge_mode, output ready);
endinterface

### rtl/cbfs_smooth.sv
// ----------------------------------------------------------------------------
// cbfs_smooth
// Input register, row tracking and the first (smoothing) three-tap stage.
// Registers the smoothed value with the history the compensating stage needs.
// ----------------------------------------------------------------------------
module cbfs_smooth #(
    parameter int W = cbfs_pkg::ValueBitsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x   [cbfs_pkg::NumFields],
    input  logic                i_end,
    input  logic                i_edge_mode,
    output logic                o_busy,
    output logic                o_valid,
    output cbfs_pkg::t_emit     o_emit,
    output logic signed [W-1:0] o_s   [cbfs_pkg::NumFields],
    output logic signed [W-1:0] o_sb1 [cbfs_pkg::NumFields],
    output logic signed [W-1:0] o_sb2 [cbfs_pkg::NumFields],
    output logic signed [W-1:0] o_x   [cbfs_pkg::NumFields]
);
    localparam int N  = cbfs_pkg::NumFields;
    localparam int EW = W + 4;

    typedef enum logic [1:0] {
        PH_GHOST,
        PH_FIRST,
        PH_SECOND,
        PH_STEADY
    } t_phase;

    t_phase              r_phase;
    logic                r_in_valid;
    logic signed [W-1:0] r_x    [N];
    logic                r_end;
    logic signed [W-1:0] r_raw1 [N];
    logic signed [W-1:0] r_raw2 [N];
    logic signed [W-1:0] r_sm1  [N];
    logic signed [W-1:0] r_sm2  [N];

    logic                r_out_valid;
    cbfs_pkg::t_emit     r_emit;
    logic signed [W-1:0] r_s    [N];
    logic signed [W-1:0] r_sb1  [N];
    logic signed [W-1:0] r_sb2  [N];
    logic signed [W-1:0] r_xo   [N];

    logic signed [EW-1:0] a_e   [N];
    logic signed [EW-1:0] b_e   [N];
    logic signed [EW-1:0] x_e   [N];
    logic signed [EW-1:0] sum_e [N];
    logic signed [EW-1:0] qtr_e [N];
    logic signed [W-1:0]  smooth   [N];
    logic signed [W-1:0]  ghost_sm [N];
    cbfs_pkg::t_emit      emit;

    // Smoothing tap: (2*centre + left + right + 2) >> 2. On the second cell
    // the left neighbour of the ghost is extrapolated as 2*ghost - right.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            a_e[i] = EW'(r_raw1[i]);
            x_e[i] = EW'(r_x[i]);
            if (r_phase == PH_FIRST) begin
                b_e[i] = (a_e[i] <<< 1) - x_e[i];
            end else begin
                b_e[i] = EW'(r_raw2[i]);
            end
            sum_e[i]    = (a_e[i] <<< 1) + b_e[i] + x_e[i] + EW'(2);
            qtr_e[i]    = sum_e[i] >>> 2;
            smooth[i]   = qtr_e[i][W-1:0];
            ghost_sm[i] = i_edge_mode ? smooth[i] : r_raw1[i];
        end
    end

    // Release a middle result in steady state and a final one at row end
    always_comb begin
        emit.mid  = (r_phase == PH_STEADY);
        emit.last = r_end && ((r_phase == PH_SECOND) || (r_phase == PH_STEADY));
    end

    // Track the row, shift the history and register the stage outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_GHOST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid && (emit.mid || emit.last);
            if (i_valid) begin
                r_x   <= i_x;
                r_end <= i_end;
            end
            r_emit <= emit;
            r_s    <= smooth;
            r_sb1  <= r_sm1;
            r_sb2  <= r_sm2;
            r_xo   <= r_x;
            if (r_in_valid) begin
                case (r_phase)
                    PH_GHOST: begin
                        r_raw1  <= r_x;
                        r_phase <= r_end ? PH_GHOST : PH_FIRST;
                    end
                    PH_FIRST: begin
                        r_raw2  <= r_raw1;
                        r_raw1  <= r_x;
                        r_sm1   <= ghost_sm;
                        r_phase <= r_end ? PH_GHOST : PH_SECOND;
                    end
                    default: begin
                        if (!r_end) begin
                            r_raw2 <= r_raw1;
                            r_raw1 <= r_x;
                            r_sm2  <= r_sm1;
                            r_sm1  <= smooth;
                        end
                        r_phase <= r_end ? PH_GHOST : PH_STEADY;
                    end
                endcase
            end
        end
    end

    assign o_busy  = r_in_valid;
    assign o_valid = r_out_valid;
    assign o_emit  = r_emit;
    assign o_s     = r_s;
    assign o_sb1   = r_sb1;
    assign o_sb2   = r_sb2;
    assign o_x     = r_xo;

endmodule

### rtl/cbfs_comp.sv
// ----------------------------------------------------------------------------
// cbfs_comp
// Compensating three-tap stage: (6*centre - left - right + 2) >> 2,
// saturated to the value range, for the middle and the final result.
// ----------------------------------------------------------------------------
module cbfs_comp #(
    parameter int W = cbfs_pkg::ValueBitsDef
) (
    input  logic signed [W-1:0] i_s      [cbfs_pkg::NumFields],
    input  logic signed [W-1:0] i_sb1    [cbfs_pkg::NumFields],
    input  logic signed [W-1:0] i_sb2    [cbfs_pkg::NumFields],
    input  logic signed [W-1:0] i_x      [cbfs_pkg::NumFields],
    output logic signed [W-1:0] o_mid_c  [cbfs_pkg::NumFields],
    output logic signed [W-1:0] o_last_c [cbfs_pkg::NumFields]
);
    localparam int N  = cbfs_pkg::NumFields;
    localparam int EW = W + 4;

    // Round to nearest (ties up) after dividing by four, then clamp
    function automatic logic signed [W-1:0] sat_quarter(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] q;
        logic [EW-W:0]        top;
        q   = (v + EW'(2)) >>> 2;
        top = q[EW-1:W-1];
        if ((&top) || (~|top)) begin
            return q[W-1:0];
        end else if (q[EW-1]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    logic signed [EW-1:0] s_e   [N];
    logic signed [EW-1:0] sb1_e [N];
    logic signed [EW-1:0] sb2_e [N];
    logic signed [EW-1:0] x_e   [N];

    // Middle result centres on the cell two back; final result on the last
    // interior cell, with the raw right ghost as its right neighbour
    always_comb begin
        for (int i = 0; i < N; i++) begin
            s_e[i]      = EW'(i_s[i]);
            sb1_e[i]    = EW'(i_sb1[i]);
            sb2_e[i]    = EW'(i_sb2[i]);
            x_e[i]      = EW'(i_x[i]);
            o_mid_c[i]  = sat_quarter((sb1_e[i] <<< 2) + (sb1_e[i] <<< 1) - sb2_e[i] - s_e[i]);
            o_last_c[i] = sat_quarter((s_e[i] <<< 2) + (s_e[i] <<< 1) - sb1_e[i] - x_e[i]);
        end
    end

endmodule

### rtl/cbfs_queue.sv
// ----------------------------------------------------------------------------
// cbfs_queue
// Result queue: takes up to two results a cycle, in order, and hands one
// result a cycle to the output channel while that channel is ready.
// ----------------------------------------------------------------------------
module cbfs_queue #(
    parameter int W     = cbfs_pkg::ValueBitsDef,
    parameter int DEPTH = cbfs_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push_mid,
    input  logic                         i_push_last,
    input  logic signed [W-1:0]          i_mid_c  [cbfs_pkg::NumFields],
    input  logic signed [W-1:0]          i_last_c [cbfs_pkg::NumFields],
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic signed [W-1:0]          o_data   [cbfs_pkg::NumFields],
    output logic                         o_last,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int N  = cbfs_pkg::NumFields;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic signed [W-1:0] r_mem      [DEPTH][N];
    logic                r_mem_last [DEPTH];
    logic [AW-1:0]       r_wr;
    logic [AW-1:0]       r_rd;
    logic [CW-1:0]       r_count;

    logic [AW-1:0]       n_wr;
    logic [AW-1:0]       n_rd;
    logic [CW-1:0]       n_count;
    logic [AW-1:0]       wr_last;
    logic                pop;

    function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
        return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    // Advance pointers by the number of pushes and pops
    always_comb begin
        pop     = o_valid && i_ready;
        wr_last = i_push_mid ? step(r_wr) : r_wr;
        n_wr    = i_push_last ? step(wr_last) : wr_last;
        n_rd    = pop ? step(r_rd) : r_rd;
        n_count = r_count + CW'(i_push_mid) + CW'(i_push_last) - CW'(pop);
    end

    // Hold pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Write the middle result first, the final one after it
    always_ff @(posedge i_clk) begin
        if (i_push_mid) begin
            r_mem[r_wr]      <= i_mid_c;
            r_mem_last[r_wr] <= 1'b0;
        end
        if (i_push_last) begin
            r_mem[wr_last]      <= i_last_c;
            r_mem_last[wr_last] <= 1'b1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_last  = r_mem_last[r_rd];
    assign o_count = r_count;

endmodule

### rtl/compensated_binomial_field_smoother.sv
// ----------------------------------------------------------------------------
// compensated_binomial_field_smoother
// Two-stage binomial smoother with compensation over rows of grid cells.
// ----------------------------------------------------------------------------
// Streams one row of cells, left ghost first and right ghost (row_end) last,
// and returns the filtered interior cells in order with out_last on the final
// one; four field lanes run side by side. A cell can be accepted every clock
// unless the input is held off: it sits in an input register, the smoothing
// stage result in a stage register, and the compensated result is written
// into the output queue, from which it can leave. The row-end cell of a row
// with two or more interior cells releases two results at once; they drain
// one per cycle, while the output is ready, from a QUEUE_DEPTH-entry result
// queue. The input request is held off only while queued and in-flight
// results could fill that queue, which in a steady stream of rows does not
// happen. edge_mode is taken on the configuration channel at any time and
// applies to every row whose second cell is processed after the write.
// ----------------------------------------------------------------------------
module compensated_binomial_field_smoother #(
    parameter int VALUE_BITS  = cbfs_pkg::ValueBitsDef,
    parameter int QUEUE_DEPTH = cbfs_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbfs_cell_if.sink     i_cell,
    cbfs_result_if.source o_result,
    cbfs_cfg_if.sink      i_cfg
);
    localparam int N  = cbfs_pkg::NumFields;
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int OW = CW + 2;

    logic                      r_edge_mode;
    logic                      accept;
    logic signed [VALUE_BITS-1:0] x      [N];
    logic                      sm_busy;
    logic                      sm_valid;
    cbfs_pkg::t_emit           sm_emit;
    logic signed [VALUE_BITS-1:0] sm_s   [N];
    logic signed [VALUE_BITS-1:0] sm_sb1 [N];
    logic signed [VALUE_BITS-1:0] sm_sb2 [N];
    logic signed [VALUE_BITS-1:0] sm_x   [N];
    logic signed [VALUE_BITS-1:0] mid_c  [N];
    logic signed [VALUE_BITS-1:0] last_c [N];
    logic signed [VALUE_BITS-1:0] q_data [N];
    logic [CW-1:0]             q_count;
    logic [OW-1:0]             reserved;

    // Take edge mode writes whenever they are requested
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_edge_mode <= i_cfg.edge_mode;
        end
    end

    // Reserve two queue slots for every cell still in the stages
    always_comb begin
        reserved     = OW'(q_count) + (OW'(sm_busy) << 1) + (OW'(sm_valid) << 1);
        i_cell.ready = i_rst_n && (reserved <= OW'(QUEUE_DEPTH - 2));
        accept       = i_cell.valid && i_cell.ready;
    end

    always_comb begin
        x[cbfs_pkg::FieldPr] = i_cell.pr_in;
        x[cbfs_pkg::FieldPl] = i_cell.pl_in;
        x[cbfs_pkg::FieldSr] = i_cell.sr_in;
        x[cbfs_pkg::FieldSl] = i_cell.sl_in;
    end

    cbfs_smooth #(
        .W (VALUE_BITS)
    ) u_smooth (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_x         (x),
        .i_end       (i_cell.row_end),
        .i_edge_mode (r_edge_mode),
        .o_busy      (sm_busy),
        .o_valid     (sm_valid),
        .o_emit      (sm_emit),
        .o_s         (sm_s),
        .o_sb1       (sm_sb1),
        .o_sb2       (sm_sb2),
        .o_x         (sm_x)
    );

    cbfs_comp #(
        .W (VALUE_BITS)
    ) u_comp (
        .i_s      (sm_s),
        .i_sb1    (sm_sb1),
        .i_sb2    (sm_sb2),
        .i_x      (sm_x),
        .o_mid_c  (mid_c),
        .o_last_c (last_c)
    );

    cbfs_queue #(
        .W     (VALUE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_mid  (sm_valid && sm_emit.mid),
        .i_push_last (sm_valid && sm_emit.last),
        .i_mid_c     (mid_c),
        .i_last_c    (last_c),
        .i_ready     (o_result.ready),
        .o_valid     (o_result.valid),
        .o_data      (q_data),
        .o_last      (o_result.out_last),
        .o_count     (q_count)
    );

    assign o_result.pr_out = q_data[cbfs_pkg::FieldPr];
    assign o_result.pl_out = q_data[cbfs_pkg::FieldPl];
    assign o_result.sr_out = q_data[cbfs_pkg::FieldSr];
    assign o_result.sl_out = q_data[cbfs_pkg::FieldSl];

endmodule

### rtl/cbfs_checker.sv
// ----------------------------------------------------------------------------
// cbfs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module cbfs_checker #(
    parameter int W = cbfs_pkg::ValueBitsDef
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic signed [W-1:0] i_out_pr,
    input logic signed [W-1:0] i_out_pl,
    input logic signed [W-1:0] i_out_sr,
    input logic signed [W-1:0] i_out_sl,
    input logic                i_out_last
);

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_out_pr, i_out_pl, i_out_sr, i_out_sl, i_out_last}))
        else $error("stalled result changed");

    // A fresh result only follows a cell taken through the input and stage registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 3))
        else $error("result appeared without a cell three cycles earlier");

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind compensated_binomial_field_smoother cbfs_checker #(
    .W (VALUE_BITS)
) u_cbfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pr    (o_result.pr_out),
    .i_out_pl    (o_result.pl_out),
    .i_out_sr    (o_result.sr_out),
    .i_out_sl    (o_result.sl_out),
    .i_out_last  (o_result.out_last)
);
